/* sv/pee_pkg.sv */
package pee_pkg;

    localparam int VAL_W = 48;
    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OVER  = 3'd1,
        ST_UNDER = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_INVAL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

endpackage

/* sv/pee_stack.sv */
module pee_stack #(
    parameter int DEPTH = pee_pkg::DEF_STACK_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [pee_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [pee_pkg::VAL_W-1:0] rdata
);
    import pee_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pee_alu.sv */
module pee_alu #(
    parameter int FRAC = pee_pkg::DEF_FRACTION_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pee_pkg::alu_ctl_t         ctl,
    input  logic [pee_pkg::VAL_W-1:0] a,
    input  logic [pee_pkg::VAL_W-1:0] b,
    output logic                      done,
    output logic [pee_pkg::VAL_W-1:0] result
);
    import pee_pkg::*;

    localparam int NUM_W = VAL_W + FRAC;
    localparam int MW    = 2 * VAL_W;
    localparam int SW    = $clog2(NUM_W);
    localparam int AD_W  = VAL_W + 2;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } alu_state_t;

    alu_state_t        state_reg;
    alu_op_t           op_reg;
    logic              neg_reg;
    logic [VAL_W-1:0]  opd_reg;
    logic [MW-1:0]     prod_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [SW-1:0]     step_reg;
    logic [VAL_W-1:0]  result_reg;
    logic              done_reg;

    logic [AD_W-1:0]   add_x;
    logic [AD_W-1:0]   add_y;
    logic              add_sub;
    logic [AD_W-1:0]   add_sum;
    logic              add_ovf;
    logic [VAL_W:0]    r2;
    logic              div_ge;
    logic              mul_sat;
    logic [VAL_W-2:0]  mul_mag;
    logic              div_sat;
    logic [VAL_W-2:0]  div_mag;

    function automatic logic [VAL_W-1:0] sat_apply(input logic sat, input logic [VAL_W-2:0] mag,
                                                   input logic neg);
        logic [VAL_W-1:0] m;
        m = {1'b0, mag};
        if (sat) begin
            return neg ? VAL_MIN : VAL_MAX;
        end
        return neg ? (~m + VAL_W'(1)) : m;
    endfunction

    assign r2      = {rem_reg, quo_reg[NUM_W-1]};
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + AD_W'(add_sub);
    assign add_ovf = !(add_sum[AD_W-1:VAL_W-1] == 3'b000 || add_sum[AD_W-1:VAL_W-1] == 3'b111);
    assign div_ge  = ~add_sum[AD_W-1];
    assign mul_sat = |prod_reg[MW-1:FRAC+VAL_W-1];
    assign mul_mag = prod_reg[FRAC+VAL_W-2:FRAC];
    assign div_sat = |quo_reg[NUM_W-1:VAL_W-1];
    assign div_mag = quo_reg[VAL_W-2:0];

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_IDLE: begin
                add_x   = {{2{a[VAL_W-1]}}, a};
                add_y   = {{2{b[VAL_W-1]}}, b};
                add_sub = (ctl.op == OP_SUB);
            end
            A_MUL: begin
                add_x = {2'b00, prod_reg[MW-1:VAL_W]};
                add_y = prod_reg[0] ? {2'b00, opd_reg} : '0;
            end
            A_DIV: begin
                add_x   = {1'b0, r2};
                add_y   = {2'b00, opd_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                A_IDLE: begin
                    done_reg <= ctl.start && (ctl.op == OP_ADD || ctl.op == OP_SUB);
                    if (ctl.start) begin
                        op_reg  <= ctl.op;
                        neg_reg <= a[VAL_W-1] ^ b[VAL_W-1];
                        unique case (ctl.op)
                            OP_ADD, OP_SUB: begin
                                if (add_ovf) begin
                                    result_reg <= add_sum[AD_W-1] ? VAL_MIN : VAL_MAX;
                                end else begin
                                    result_reg <= add_sum[VAL_W-1:0];
                                end
                            end
                            OP_MUL: begin
                                opd_reg   <= mag_of(a);
                                prod_reg  <= {{VAL_W{1'b0}}, mag_of(b)};
                                step_reg  <= '0;
                                state_reg <= A_MUL;
                            end
                            OP_DIV: begin
                                opd_reg   <= mag_of(b);
                                quo_reg   <= NUM_W'(mag_of(a)) << FRAC;
                                rem_reg   <= '0;
                                step_reg  <= '0;
                                state_reg <= A_DIV;
                            end
                            default: begin
                                state_reg <= A_IDLE;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    done_reg <= 1'b0;
                    prod_reg <= {add_sum[VAL_W:0], prod_reg[VAL_W-1:1]};
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(VAL_W - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_DIV: begin
                    done_reg <= 1'b0;
                    rem_reg  <= div_ge ? add_sum[VAL_W-1:0] : r2[VAL_W-1:0];
                    quo_reg  <= {quo_reg[NUM_W-2:0], div_ge};
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(NUM_W - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    if (op_reg == OP_MUL) begin
                        result_reg <= sat_apply(mul_sat, mul_mag, neg_reg);
                    end else begin
                        result_reg <= sat_apply(div_sat, div_mag, neg_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/postfix_expression_evaluator.sv */
// Items are handled one at a time: s_ready stays low until the current item, including the
// bit-serial multiply/divide loop of the shared arithmetic unit, is finished; an item marked
// last also waits for the output register to be free while m_ready stalls. On an error or an
// empty stack the last item reports its status without reading the top of the stack.
// Reset: synchronous, active-low aresetn empties the stack, clears the error and
// drops any pending result; stack entries themselves are not cleared.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH   = pee_pkg::DEF_STACK_DEPTH,
    parameter int FRACTION_BITS = pee_pkg::DEF_FRACTION_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_symbol,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pee_pkg::VAL_W-1:0] m_value,
    output logic [2:0]                       m_status
);
    import pee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_L,
        S_OPER,
        S_WAIT,
        S_FINISH,
        S_TOP,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [7:0]       sym_reg;
    logic             last_reg;
    logic [CW-1:0]    count_reg;
    status_t          err_reg;
    logic [VAL_W-1:0] right_reg;
    logic [VAL_W-1:0] res_value_reg;
    status_t          res_status_reg;
    logic             m_valid_reg;
    logic [VAL_W-1:0] m_value_reg;
    status_t          m_status_reg;

    logic [CW-1:0]    cnt_m1;
    logic [CW-1:0]    cnt_m2;
    logic             is_digit;
    logic             is_full;
    logic [3:0]       digit;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    alu_ctl_t         alu_ctl;
    logic             alu_done;
    logic [VAL_W-1:0] alu_result;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign is_digit = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign digit    = 4'(sym_reg - CH_ZERO);

    assign mem_waddr = count_reg[AW-1:0];
    assign mem_raddr = (state_reg == S_RD_L) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

    always_comb begin
        mem_we        = 1'b0;
        mem_wdata     = alu_result;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = OP_ADD;
        unique case (state_reg)
            S_DECODE: begin
                mem_wdata = VAL_W'(digit) << FRACTION_BITS;
                mem_we    = (err_reg == ST_OK) && is_digit && !is_full;
            end
            S_OPER: begin
                unique case (sym_reg)
                    CH_PLUS: begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.op    = OP_ADD;
                    end
                    CH_MINUS: begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.op    = OP_SUB;
                    end
                    CH_TIMES: begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.op    = OP_MUL;
                    end
                    CH_SLASH: begin
                        alu_ctl.start = (right_reg != '0);
                        alu_ctl.op    = OP_DIV;
                    end
                    default: begin
                        alu_ctl.start = 1'b0;
                    end
                endcase
            end
            S_WAIT: begin
                mem_we = alu_done;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    pee_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    pee_alu #(
        .FRAC(FRACTION_BITS)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (alu_ctl),
        .a      (mem_rdata),
        .b      (right_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        sym_reg   <= s_symbol;
                        last_reg  <= s_last;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (err_reg != ST_OK) begin
                        state_reg <= S_FINISH;
                    end else if (is_digit) begin
                        if (is_full) begin
                            err_reg <= ST_OVER;
                        end else begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_FINISH;
                    end else if (count_reg < CW'(2)) begin
                        err_reg   <= ST_UNDER;
                        state_reg <= S_FINISH;
                    end else begin
                        state_reg <= S_RD_L;
                    end
                end
                S_RD_L: begin
                    right_reg <= mem_rdata;
                    state_reg <= S_OPER;
                end
                S_OPER: begin
                    count_reg <= cnt_m2;
                    if (alu_ctl.start) begin
                        state_reg <= S_WAIT;
                    end else begin
                        err_reg   <= (sym_reg == CH_SLASH) ? ST_DIVZ : ST_INVAL;
                        state_reg <= S_FINISH;
                    end
                end
                S_WAIT: begin
                    if (alu_done) begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (err_reg != ST_OK) begin
                        res_value_reg  <= '0;
                        res_status_reg <= err_reg;
                        state_reg      <= S_OUT;
                    end else if (count_reg == '0) begin
                        res_value_reg  <= '0;
                        res_status_reg <= ST_UNDER;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_TOP;
                    end
                end
                S_TOP: begin
                    res_value_reg  <= mem_rdata;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        count_reg    <= '0;
                        err_reg      <= ST_OK;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> count_reg < CW'(STACK_DEPTH))
        else $error("stack write while full");

    alu_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> state_reg == S_WAIT)
        else $error("arithmetic result outside wait state");

    alu_start_in_oper: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_ctl.start |-> state_reg == S_OPER && count_reg >= CW'(2))
        else $error("arithmetic start without two operands");

    clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && count_reg == '0 && err_reg == ST_OK))
        else $error("evaluator not cleared after result transfer");
`endif

endmodule
